// ----- rtl/wsfp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and codes of the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 64;
    localparam int KIND_W  = 2;
    localparam int EVENT_W = 3;
    localparam int OPC_W   = 4;
    localparam int EXT_W   = 3;

    // Parser phase within one frame
    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // Frame class, judged at frame start
    typedef enum logic [2:0] {
        CLS_FRAG   = 3'd0,
        CLS_SINGLE = 3'd1,
        CLS_PING   = 3'd2,
        CLS_CLOSE  = 3'd3,
        CLS_PONG   = 3'd4,
        CLS_ERROR  = 3'd5
    } t_class;

    // Opcodes
    localparam logic [OPC_W-1:0] OPC_CONT   = 4'h0;
    localparam logic [OPC_W-1:0] OPC_TEXT   = 4'h1;
    localparam logic [OPC_W-1:0] OPC_BINARY = 4'h2;
    localparam logic [OPC_W-1:0] OPC_CLOSE  = 4'h8;
    localparam logic [OPC_W-1:0] OPC_PING   = 4'h9;
    localparam logic [OPC_W-1:0] OPC_PONG   = 4'hA;

    // Message kinds
    localparam logic [KIND_W-1:0] KIND_FRAG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PING   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd3;

    // Frame events
    localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_READY = 3'd1;
    localparam logic [EVENT_W-1:0] EV_PING  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_CLOSE = 3'd3;
    localparam logic [EVENT_W-1:0] EV_ERROR = 3'd4;

    // Length byte fields
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;

    // Number of extension bytes, modulo eight
    localparam logic [EXT_W-1:0] EXT16_BYTES = 3'd2;
    localparam logic [EXT_W-1:0] EXT64_BYTES = 3'd0;

    // One result word
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               has_byte;
        logic [KIND_W-1:0]  msg_kind;
        logic [EVENT_W-1:0] frame_event;
        logic               restart_flag;
    } t_result;

endpackage

// ----- rtl/websocket_frame_parser.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Parses unmasked server-to-client WebSocket frames, one byte per word, and
// streams tagged payload bytes and frame-end events.
// ----------------------------------------------------------------------------
// Channel   Dir  Word                 Fields (low bit first)
// s_axis    in   one received byte    tdata[7:0] rx_byte
// m_axis    out  zero or one result   tdata[7:0] out_byte;
//                                     tuser has_byte, msg_kind, frame_event,
//                                     restart_flag
//
// One byte is accepted per cycle unless a stall on m_axis holds the flow; the
// frame state update fits between the input register and the result register.
// A result passes through the input register and the result register before it
// is on m_axis; bytes that give no result leave nothing.
// Reset clears the frame state and the halt; no clearing pass is needed.
// A stall on m_axis fills the result register and then the input register
// before s_axis_tready falls; no word is lost or repeated.
// ----------------------------------------------------------------------------
module websocket_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [6:0] m_axis_tuser    // [0] has_byte, [2:1] msg_kind,
                                       // [5:3] frame_event, [6] restart_flag
);

    logic                        w_in_valid;
    logic [wsfp_pkg::BYTE_W-1:0] w_in_byte;
    logic                        w_take;
    logic                        w_out_ready;
    logic                        w_res_valid;
    wsfp_pkg::t_result           w_res;
    wsfp_pkg::t_result           w_out_res;

    // Input register
    wsfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (w_in_valid),
        .o_data  (w_in_byte),
        .i_take  (w_take)
    );

    // Frame parser
    wsfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_valid),
        .i_byte      (w_in_byte),
        .i_out_ready (w_out_ready),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register
    wsfp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_res   (w_res),
        .o_ready (w_out_ready),
        .o_valid (m_axis_tvalid),
        .o_res   (w_out_res),
        .i_ready (m_axis_tready)
    );

    // Pack the result word
    assign m_axis_tdata = w_out_res.out_byte;
    assign m_axis_tuser = {w_out_res.restart_flag, w_out_res.frame_event,
                           w_out_res.msg_kind, w_out_res.has_byte};

endmodule

// ----- rtl/wsfp_in_reg.sv -----
// ----------------------------------------------------------------------------
// wsfp_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsfp_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [wsfp_pkg::BYTE_W-1:0] i_data,
    output logic                        o_valid,
    output logic [wsfp_pkg::BYTE_W-1:0] o_data,
    input  logic                        i_take
);

    logic                        r_valid;
    logic [wsfp_pkg::BYTE_W-1:0] r_data;

    // Accept when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the byte
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// ----- rtl/wsfp_parser.sv -----
// ----------------------------------------------------------------------------
// wsfp_parser
// Frame state machine: updates the header and length state for each byte
// and forms at most one result word.
// ----------------------------------------------------------------------------
module wsfp_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [wsfp_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_out_ready,
    output logic                        o_take,
    output logic                        o_res_valid,
    output wsfp_pkg::t_result           o_res
);

    wsfp_pkg::t_phase             r_phase, n_phase;
    logic [wsfp_pkg::EXT_W-1:0]   r_ext_count, n_ext_count;
    logic                         r_fin, n_fin;
    logic [wsfp_pkg::OPC_W-1:0]   r_opcode, n_opcode;
    logic [wsfp_pkg::LEN_W-1:0]   r_remaining, n_remaining;
    logic                         r_frag_open, n_frag_open;
    logic                         r_halted, n_halted;

    wsfp_pkg::t_class             w_cls;
    logic [wsfp_pkg::EVENT_W-1:0] w_end_event;
    logic [wsfp_pkg::KIND_W-1:0]  w_kind;
    logic [wsfp_pkg::EXT_W-1:0]   w_ext_inc;
    logic [wsfp_pkg::LEN_W-1:0]   w_len;
    logic [wsfp_pkg::LEN_W-1:0]   w_rem_dec;
    logic [6:0]                   w_code;
    logic                         w_mask;
    logic                         w_hdr_done;
    logic                         w_frame_end;
    logic                         w_start_unfin;
    logic                         w_clear_frag;

    // Classify the current frame
    function automatic wsfp_pkg::t_class f_class(
        input logic [wsfp_pkg::OPC_W-1:0] opcode,
        input logic                       fin,
        input logic                       frag_open
    );
        wsfp_pkg::t_class cls;
        case (opcode)
            wsfp_pkg::OPC_CONT:   cls = frag_open ? wsfp_pkg::CLS_FRAG : wsfp_pkg::CLS_ERROR;
            wsfp_pkg::OPC_TEXT,
            wsfp_pkg::OPC_BINARY: cls = fin ? wsfp_pkg::CLS_SINGLE : wsfp_pkg::CLS_FRAG;
            wsfp_pkg::OPC_CLOSE:  cls = wsfp_pkg::CLS_CLOSE;
            wsfp_pkg::OPC_PING:   cls = wsfp_pkg::CLS_PING;
            wsfp_pkg::OPC_PONG:   cls = wsfp_pkg::CLS_PONG;
            default:              cls = wsfp_pkg::CLS_ERROR;
        endcase
        return cls;
    endfunction

    // Event given when a frame of this class ends
    function automatic logic [wsfp_pkg::EVENT_W-1:0] f_end_event(
        input wsfp_pkg::t_class           cls,
        input logic [wsfp_pkg::OPC_W-1:0] opcode,
        input logic                       fin
    );
        logic [wsfp_pkg::EVENT_W-1:0] ev;
        case (cls)
            wsfp_pkg::CLS_FRAG:   ev = (opcode == wsfp_pkg::OPC_CONT && fin) ?
                                       wsfp_pkg::EV_READY : wsfp_pkg::EV_NONE;
            wsfp_pkg::CLS_SINGLE: ev = wsfp_pkg::EV_READY;
            wsfp_pkg::CLS_PING:   ev = wsfp_pkg::EV_PING;
            wsfp_pkg::CLS_CLOSE:  ev = wsfp_pkg::EV_CLOSE;
            wsfp_pkg::CLS_PONG:   ev = wsfp_pkg::EV_NONE;
            default:              ev = wsfp_pkg::EV_ERROR;
        endcase
        return ev;
    endfunction

    // Message kind carried by results of this class
    function automatic logic [wsfp_pkg::KIND_W-1:0] f_kind(input wsfp_pkg::t_class cls);
        logic [wsfp_pkg::KIND_W-1:0] kind;
        case (cls)
            wsfp_pkg::CLS_SINGLE: kind = wsfp_pkg::KIND_SINGLE;
            wsfp_pkg::CLS_PING:   kind = wsfp_pkg::KIND_PING;
            wsfp_pkg::CLS_CLOSE:  kind = wsfp_pkg::KIND_CLOSE;
            default:              kind = wsfp_pkg::KIND_FRAG;
        endcase
        return kind;
    endfunction

    // Take a byte whenever the result register can hold its result
    assign o_take = i_valid && i_out_ready;

    // Decode helpers shared by both blocks below
    assign w_cls         = f_class(r_opcode, r_fin, r_frag_open);
    assign w_end_event   = f_end_event(w_cls, r_opcode, r_fin);
    assign w_kind        = f_kind(w_cls);
    assign w_code        = i_byte[6:0];
    assign w_mask        = i_byte[7];
    assign w_ext_inc     = r_ext_count + 3'd1;
    assign w_len         = (r_phase == wsfp_pkg::PH_HDR2) ? {57'd0, w_code}
                                                          : {r_remaining[55:0], i_byte};
    assign w_rem_dec     = (r_remaining != '0) ? r_remaining - 64'd1 : r_remaining;
    assign w_start_unfin = (r_opcode == wsfp_pkg::OPC_TEXT || r_opcode == wsfp_pkg::OPC_BINARY)
                           && !r_fin;
    assign w_clear_frag  = (w_cls == wsfp_pkg::CLS_FRAG) && (r_opcode == wsfp_pkg::OPC_CONT)
                           && r_fin;
    assign w_hdr_done    = !r_halted &&
        ((r_phase == wsfp_pkg::PH_HDR2 && !w_mask && w_code < wsfp_pkg::LEN_CODE_EXT16) ||
         (r_phase == wsfp_pkg::PH_EXT16 && w_ext_inc == wsfp_pkg::EXT16_BYTES) ||
         (r_phase == wsfp_pkg::PH_EXT64 && w_ext_inc == wsfp_pkg::EXT64_BYTES));
    assign w_frame_end   = w_hdr_done ? (w_len == '0) :
        (!r_halted && r_phase == wsfp_pkg::PH_PAYLOAD && w_rem_dec == '0);

    // Next state
    always_comb begin
        n_phase     = r_phase;
        n_ext_count = r_ext_count;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_remaining = r_remaining;
        n_frag_open = r_frag_open;
        n_halted    = r_halted;
        if (o_take && !r_halted) begin
            case (r_phase)
                wsfp_pkg::PH_HDR1: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_phase  = wsfp_pkg::PH_HDR2;
                end
                wsfp_pkg::PH_HDR2: begin
                    if (w_mask) begin
                        n_halted = 1'b1;
                        n_phase  = wsfp_pkg::PH_HDR1;
                    end else begin
                        // Start an extended length from zero
                        n_remaining = w_hdr_done ? w_len : '0;
                        n_ext_count = '0;
                        if (w_code == wsfp_pkg::LEN_CODE_EXT16) begin
                            n_phase = wsfp_pkg::PH_EXT16;
                        end else if (!w_hdr_done) begin
                            n_phase = wsfp_pkg::PH_EXT64;
                        end
                    end
                end
                wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
                    n_remaining = w_len;
                    n_ext_count = w_hdr_done ? '0 : w_ext_inc;
                end
                wsfp_pkg::PH_PAYLOAD: begin
                    n_remaining = w_rem_dec;
                end
                default: begin
                    n_phase = wsfp_pkg::PH_HDR1;
                end
            endcase
            // Header complete: open a fragment, enter payload
            if (w_hdr_done) begin
                if (w_start_unfin) begin
                    n_frag_open = 1'b1;
                end
                n_phase = wsfp_pkg::PH_PAYLOAD;
            end
            // Frame end: back to header, close a finished fragment
            if (w_frame_end) begin
                n_phase = wsfp_pkg::PH_HDR1;
                if (w_clear_frag) begin
                    n_frag_open = 1'b0;
                end
            end
        end
    end

    // Result word
    always_comb begin
        o_res = '0;
        if (r_halted) begin
            o_res.frame_event = wsfp_pkg::EV_ERROR;
        end else if (r_phase == wsfp_pkg::PH_HDR2 && w_mask) begin
            o_res.frame_event = wsfp_pkg::EV_ERROR;
        end else if (w_hdr_done) begin
            o_res.msg_kind     = w_kind;
            o_res.frame_event  = w_frame_end ? w_end_event : wsfp_pkg::EV_NONE;
            o_res.restart_flag = w_start_unfin && r_frag_open;
        end else if (r_phase == wsfp_pkg::PH_PAYLOAD) begin
            o_res.has_byte    = (w_cls <= wsfp_pkg::CLS_CLOSE);
            o_res.out_byte    = o_res.has_byte ? i_byte : '0;
            o_res.msg_kind    = w_kind;
            o_res.frame_event = w_frame_end ? w_end_event : wsfp_pkg::EV_NONE;
        end
        o_res_valid = o_take && (o_res.has_byte || o_res.restart_flag ||
                                 o_res.frame_event != wsfp_pkg::EV_NONE);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wsfp_pkg::PH_HDR1;
            r_ext_count <= '0;
            r_fin       <= 1'b0;
            r_opcode    <= '0;
            r_remaining <= '0;
            r_frag_open <= 1'b0;
            r_halted    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_ext_count <= n_ext_count;
            r_fin       <= n_fin;
            r_opcode    <= n_opcode;
            r_remaining <= n_remaining;
            r_frag_open <= n_frag_open;
            r_halted    <= n_halted;
        end
    end

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt cleared without reset");

    // Payload phase always has bytes left
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == wsfp_pkg::PH_PAYLOAD |-> r_remaining != '0)
        else $error("payload phase with zero length");

    // Payload bytes come only from the payload phase of a live parser
    a_byte_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.has_byte) |-> (r_phase == wsfp_pkg::PH_PAYLOAD && !r_halted))
        else $error("payload byte outside payload phase");

    // Restart marks a header end only, with no event
    a_restart_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.restart_flag) |->
            (!o_res.has_byte && o_res.frame_event == wsfp_pkg::EV_NONE && n_frag_open))
        else $error("restart flag on a non-header result");

endmodule

// ----- rtl/wsfp_out_reg.sv -----
// ----------------------------------------------------------------------------
// wsfp_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module wsfp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wsfp_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    output wsfp_pkg::t_result o_res,
    input  logic              i_ready
);

    logic              r_valid;
    wsfp_pkg::t_result r_res;

    // Accept when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the result
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for websocket_frame_parser. Builds a byte stream of
// WebSocket frames (directed corner frames, then random messages with noise),
// drives it with random gaps, stalls the result side, and compares every
// result word against an in-bench model of the parser.
// ----------------------------------------------------------------------------
import wsfp_pkg::*;

// Tracks parser state per accepted byte and checks result words in order
class frame_checker;
    t_phase            phase;
    logic [EXT_W-1:0]  ext_cnt;
    logic              fin;
    logic [OPC_W-1:0]  opc;
    logic [LEN_W-1:0]  remain;
    logic              frag_open;
    logic              halted;
    t_result           expected_words[$];
    int                fail_count;

    function new();
        phase      = PH_HDR1;
        ext_cnt    = '0;
        fin        = 1'b0;
        opc        = '0;
        remain     = '0;
        frag_open  = 1'b0;
        halted     = 1'b0;
        fail_count = 0;
    endfunction

    function int pending_count();
        return expected_words.size();
    endfunction

    // Classify the current frame against the fragment state
    function t_class frame_class();
        case (opc)
            OPC_CONT:               return frag_open ? CLS_FRAG : CLS_ERROR;
            OPC_TEXT, OPC_BINARY:   return fin ? CLS_SINGLE : CLS_FRAG;
            OPC_CLOSE:              return CLS_CLOSE;
            OPC_PING:               return CLS_PING;
            OPC_PONG:               return CLS_PONG;
            default:                return CLS_ERROR;
        endcase
    endfunction

    function logic [KIND_W-1:0] kind_of(t_class cls);
        case (cls)
            CLS_SINGLE: return KIND_SINGLE;
            CLS_PING:   return KIND_PING;
            CLS_CLOSE:  return KIND_CLOSE;
            default:    return KIND_FRAG;
        endcase
    endfunction

    // Close the frame and give its event
    function logic [EVENT_W-1:0] finish_frame(t_class cls);
        phase = PH_HDR1;
        case (cls)
            CLS_FRAG: begin
                if (opc == OPC_CONT && fin) begin
                    frag_open = 1'b0;
                    return EV_READY;
                end
                return EV_NONE;
            end
            CLS_SINGLE: return EV_READY;
            CLS_PING:   return EV_PING;
            CLS_CLOSE:  return EV_CLOSE;
            CLS_PONG:   return EV_NONE;
            default:    return EV_ERROR;
        endcase
    endfunction

    function void push_word(logic [7:0] b, logic has, logic [KIND_W-1:0] kind,
                            logic [EVENT_W-1:0] ev, logic flag);
        t_result w;
        if (!has && ev == EV_NONE && !flag)
            return;
        w.out_byte     = has ? b : 8'h00;
        w.has_byte     = has;
        w.msg_kind     = kind;
        w.frame_event  = ev;
        w.restart_flag = flag;
        expected_words.push_back(w);
    endfunction

    // Header complete, length in remain
    function void header_end();
        t_class             cls;
        logic               flag;
        logic [EVENT_W-1:0] ev;
        cls  = frame_class();
        flag = 1'b0;
        ev   = EV_NONE;
        if ((opc == OPC_TEXT || opc == OPC_BINARY) && !fin) begin
            flag      = frag_open;
            frag_open = 1'b1;
        end
        if (remain == '0)
            ev = finish_frame(cls);
        else
            phase = PH_PAYLOAD;
        push_word(8'h00, 1'b0, kind_of(cls), ev, flag);
    endfunction

    function void note_rx_byte(logic [7:0] b);
        t_class             cls;
        logic [EVENT_W-1:0] ev;
        logic [EXT_W-1:0]   need;
        if (halted) begin
            push_word(8'h00, 1'b0, KIND_FRAG, EV_ERROR, 1'b0);
            return;
        end
        case (phase)
            PH_HDR1: begin
                fin   = b[7];
                opc   = b[3:0];
                phase = PH_HDR2;
            end
            PH_HDR2: begin
                if (b[7]) begin
                    // Masked frame: halt until reset
                    halted = 1'b1;
                    phase  = PH_HDR1;
                    push_word(8'h00, 1'b0, KIND_FRAG, EV_ERROR, 1'b0);
                end else begin
                    remain  = '0;
                    ext_cnt = '0;
                    if (b[6:0] < LEN_CODE_EXT16) begin
                        remain = {57'd0, b[6:0]};
                        header_end();
                    end else begin
                        phase = (b[6:0] == LEN_CODE_EXT16) ? PH_EXT16 : PH_EXT64;
                    end
                end
            end
            PH_EXT16, PH_EXT64: begin
                need    = (phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                remain  = {remain[LEN_W-9:0], b};
                ext_cnt = ext_cnt + 1'b1;
                if (ext_cnt == need) begin
                    ext_cnt = '0;
                    header_end();
                end
            end
            PH_PAYLOAD: begin
                cls = frame_class();
                ev  = EV_NONE;
                if (remain != '0)
                    remain = remain - 1'b1;
                if (remain == '0)
                    ev = finish_frame(cls);
                push_word(b, cls <= CLS_CLOSE, kind_of(cls), ev, 1'b0);
            end
            default: phase = PH_HDR1;
        endcase
    endfunction

    function void check_word(logic [7:0] data, logic [6:0] user);
        t_result w;
        if (expected_words.size() == 0) begin
            $error("result word with none expected: tdata %0h tuser %0h", data, user);
            fail_count++;
            return;
        end
        w = expected_words.pop_front();
        if (data !== w.out_byte) begin
            $error("out_byte: expected %0h, got %0h", w.out_byte, data);
            fail_count++;
        end
        if (user[0] !== w.has_byte) begin
            $error("has_byte: expected %0d, got %0d", w.has_byte, user[0]);
            fail_count++;
        end
        if (user[2:1] !== w.msg_kind) begin
            $error("msg_kind: expected %0d, got %0d", w.msg_kind, user[2:1]);
            fail_count++;
        end
        if (user[5:3] !== w.frame_event) begin
            $error("frame_event: expected %0d, got %0d", w.frame_event, user[5:3]);
            fail_count++;
        end
        if (user[6] !== w.restart_flag) begin
            $error("restart_flag: expected %0d, got %0d", w.restart_flag, user[6]);
            fail_count++;
        end
    endfunction
endclass

module tb;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_BYTES  = 800;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          HOLD_AT_WORD  = 150;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          CALM_FIRST    = 300;
    localparam int          CALM_LAST     = 420;
    localparam int          IDLE_PERCENT  = 22;
    localparam logic [3:0]  OPC_RSVD_DATA = 4'h3;
    localparam logic [7:0]  MASK_BIT      = 8'h80;
    localparam logic [6:0]  LEN_CODE_EXT64 = 7'd127;

    // Length encodings of one frame
    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_mode;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic [6:0] m_axis_tuser;   // [0] has_byte, [2:1] msg_kind, [5:3] frame_event,
                                // [6] restart_flag

    frame_checker scb = new();
    logic [7:0]   rx_stream[$];
    int           rx_count = 0;
    int           cycle_count = 0;

    websocket_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            scb.check_word(m_axis_tdata, m_axis_tuser);
    end

    // Append one frame: header, length bytes, random payload
    task automatic add_frame(input logic fin, input logic [3:0] opc,
                             input int unsigned len, input t_len_mode mode);
        logic [2:0]       rsv;
        logic [LEN_W-1:0] len64;
        rsv   = 3'($urandom);
        len64 = LEN_W'(len);
        rx_stream.push_back({fin, rsv, opc});
        case (mode)
            LEN_SHORT: rx_stream.push_back({1'b0, len64[6:0]});
            LEN_EXT16: begin
                rx_stream.push_back({1'b0, LEN_CODE_EXT16});
                rx_stream.push_back(len64[15:8]);
                rx_stream.push_back(len64[7:0]);
            end
            default: begin
                rx_stream.push_back({1'b0, LEN_CODE_EXT64});
                for (int i = 7; i >= 0; i--)
                    rx_stream.push_back(len64[i*8 +: 8]);
            end
        endcase
        for (int unsigned i = 0; i < len; i++)
            rx_stream.push_back(8'($urandom));
    endtask

    // Random frame with mostly small lengths, now and then one near the largest short length
    task automatic add_random_frame(input logic fin, input logic [3:0] opc);
        int unsigned r;
        int unsigned len;
        t_len_mode   mode;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            mode = LEN_SHORT;
            r = $urandom_range(0, 99);
            len = (r < 70) ? $urandom_range(0, 6) :
                  (r < 92) ? $urandom_range(7, 30) : $urandom_range(120, 125);
        end else begin
            mode = (r < 90) ? LEN_EXT16 : LEN_EXT64;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 270)
                                               : $urandom_range(0, 20);
        end
        add_frame(fin, opc, len, mode);
    endtask

    task automatic add_control_frame();
        logic [3:0] opc;
        case ($urandom_range(0, 2))
            0:       opc = OPC_CLOSE;
            1:       opc = OPC_PING;
            default: opc = OPC_PONG;
        endcase
        add_random_frame($urandom_range(0, 7) != 0, opc);
    endtask

    task automatic build_stream();
        int unsigned r;
        int unsigned n;
        logic [3:0]  opc;
        // Directed corner frames
        add_frame(1'b1, OPC_TEXT,      0, LEN_SHORT);   // empty single text
        add_frame(1'b1, OPC_BINARY,    1, LEN_SHORT);   // one byte single binary
        add_frame(1'b1, OPC_PING,      0, LEN_SHORT);
        add_frame(1'b1, OPC_CLOSE,     1, LEN_SHORT);
        add_frame(1'b1, OPC_PONG,      1, LEN_SHORT);   // payload dropped
        add_frame(1'b1, OPC_CONT,      0, LEN_SHORT);   // orphan continuation
        add_frame(1'b1, OPC_RSVD_DATA, 1, LEN_SHORT);   // unknown opcode
        add_frame(1'b0, OPC_TEXT,      1, LEN_SHORT);   // open fragment
        add_frame(1'b1, OPC_BINARY,    0, LEN_SHORT);   // single inside fragment
        add_frame(1'b0, OPC_BINARY,    0, LEN_SHORT);   // restart of fragment
        add_frame(1'b1, OPC_CONT,      1, LEN_SHORT);   // fragment done
        // Random messages with interleaved control frames and noise
        while (rx_stream.size() < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                add_random_frame(1'b1, $urandom_range(0, 1) ? OPC_TEXT : OPC_BINARY);
            end else if (r < 62) begin
                add_random_frame(1'b0, $urandom_range(0, 1) ? OPC_TEXT : OPC_BINARY);
                n = $urandom_range(0, 3);
                for (int unsigned i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0)
                        add_control_frame();
                    add_random_frame(1'b0, OPC_CONT);
                end
                // Leave some fragments unfinished so a later start restarts them
                if ($urandom_range(0, 9) != 0)
                    add_random_frame(1'b1, OPC_CONT);
            end else if (r < 82) begin
                add_control_frame();
            end else if (r < 91) begin
                add_random_frame(1'($urandom_range(0, 1)), OPC_CONT);
            end else begin
                do
                    opc = 4'($urandom);
                while (opc == OPC_CONT || opc == OPC_TEXT || opc == OPC_BINARY ||
                       opc == OPC_CLOSE || opc == OPC_PING || opc == OPC_PONG);
                add_random_frame(1'($urandom_range(0, 1)), opc);
            end
        end
        // Masked frame halts the parser; later bytes all report errors
        rx_stream.push_back({1'b1, 3'b000, OPC_TEXT});
        rx_stream.push_back(MASK_BIT | 8'($urandom_range(0, 127)));
        for (int i = 0; i < 6; i++)
            rx_stream.push_back(8'($urandom));
    endtask

    // Offer one byte, with random gaps, until it is accepted
    task automatic send_word(input logic [7:0] b);
        bit sent;
        sent = 1'b0;
        while (!sent) begin
            @(negedge i_clk);
            if (!(rx_count >= CALM_FIRST && rx_count < CALM_LAST) &&
                $urandom_range(0, 99) < IDLE_PERCENT) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= b;
                @(posedge i_clk);
                while (!s_axis_tready)
                    @(posedge i_clk);
                scb.note_rx_byte(b);
                rx_count++;
                sent = 1'b1;
            end
        end
    endtask

    // Result side: random stalls, one long hold-off, one calm stretch
    initial begin
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && rx_count >= HOLD_AT_WORD) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= (rx_count >= CALM_FIRST && rx_count < CALM_LAST) ||
                                 ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin
        build_stream();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (rx_stream[i])
            send_word(rx_stream[i]);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        // Drain, then watch for stray words
        while (scb.pending_count() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scb.fail_count == 0 && scb.pending_count() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
